// File: rtl/mpsm_pkg.sv
`default_nettype none
package mpsm_pkg;

   localparam int DEF_SLOTS       = 10;
   localparam int DEF_PATTERN_LEN = 256;

   localparam logic [7:0] ESC_BYTE = 8'h01;

   typedef enum logic [1:0] {
      ACT_RX    = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_ARM   = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   // how the working count changes
   typedef enum logic [2:0] {
      CNT_KEEP = 3'd0,
      CNT_LOAD = 3'd1,
      CNT_INC  = 3'd2,
      CNT_LEN  = 3'd3,
      CNT_J1   = 3'd4,
      CNT_ZERO = 3'd5
   } cnt_op_type;

   // which pattern bytes to fetch
   typedef enum logic [2:0] {
      RD_NONE    = 3'd0,
      RD_CNT     = 3'd1,
      RD_J_FIRST = 3'd2,
      RD_J_DEC   = 3'd3,
      RD_I_FIRST = 3'd4,
      RD_I_NEXT  = 3'd5
   } rd_op_type;

   typedef struct packed {
      logic       accept;
      cnt_op_type cnt;
      rd_op_type  rd;
      logic       commit;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic feed;
      logic armed;
      logic lt_len;
      logic cnt_zero;
      logic a_eq_b;
      logic pair_eq;
      logic j_zero;
      logic i_last;
      logic last_slot;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/mpsm_req_if.sv
`default_nettype none
interface mpsm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [3:0] slot;
   logic [7:0] position;
   logic [7:0] byte_value;
   logic [8:0] pattern_length;

   modport source (output valid, action, slot, position, byte_value, pattern_length,
                   input ready);
   modport sink (input valid, action, slot, position, byte_value, pattern_length,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/mpsm_rsp_if.sv
`default_nettype none
interface mpsm_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] match_slot;
   logic       byte_fed;
   logic [7:0] decoded_byte;

   modport source (output valid, match_slot, byte_fed, decoded_byte, input ready);
   modport sink (input valid, match_slot, byte_fed, decoded_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/multi_pattern_stream_matcher.sv
// write, arm, clear and swallowed escape words: result word one cycle after accept
// received byte: 2 cycles per unarmed slot and 3 per armed slot, plus one cycle
// per candidate border and one per compared byte pair while the border search
// walks the prefixes, plus one cycle to finish; next word once the result is free
// the pattern store has one write and two registered read ports
// synchronous reset disarms all slots and clears lengths, counts and escape
module multi_pattern_stream_matcher
   import mpsm_pkg::*;
#(
   parameter int SLOTS       = DEF_SLOTS,
   parameter int PATTERN_LEN = DEF_PATTERN_LEN
) (
   input wire logic clock,
   input wire logic reset,
   mpsm_req_if.sink   req_bus,
   mpsm_rsp_if.source rsp_bus
);

   cmd_type    cmd;
   status_type sts;
   logic       rsp_valid;

   assign rsp_bus.valid = rsp_valid;

   mpsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mpsm_dp #(
      .SLOTS       (SLOTS),
      .PATTERN_LEN (PATTERN_LEN)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_bus.action),
      .req_slot           (req_bus.slot),
      .req_position       (req_bus.position),
      .req_byte_value     (req_bus.byte_value),
      .req_pattern_length (req_bus.pattern_length),
      .rsp_take           (rsp_valid && rsp_bus.ready),
      .rsp_valid          (rsp_valid),
      .rsp_match_slot     (rsp_bus.match_slot),
      .rsp_byte_fed       (rsp_bus.byte_fed),
      .rsp_decoded_byte   (rsp_bus.decoded_byte)
   );

endmodule
`default_nettype wire

// File: rtl/mpsm_dp.sv
`default_nettype none
module mpsm_dp
   import mpsm_pkg::*;
#(
   parameter int SLOTS       = DEF_SLOTS,
   parameter int PATTERN_LEN = DEF_PATTERN_LEN
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   output status_type      sts,
   input  wire logic [1:0] req_action,
   input  wire logic [3:0] req_slot,
   input  wire logic [7:0] req_position,
   input  wire logic [7:0] req_byte_value,
   input  wire logic [8:0] req_pattern_length,
   input  wire logic       rsp_take,
   output logic            rsp_valid,
   output logic [3:0]      rsp_match_slot,
   output logic            rsp_byte_fed,
   output logic [7:0]      rsp_decoded_byte
);

   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = $clog2(PATTERN_LEN + 1);
   localparam int PW    = $clog2(PATTERN_LEN);
   localparam int DEPTH = SLOTS * PATTERN_LEN;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = (CW > 9) ? CW : 9;

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_a_ff, rd_b_ff;
   logic [CW-1:0] len_ff [SLOTS];
   logic [CW-1:0] cnt_tab_ff [SLOTS];
   logic [SLOTS-1:0] armed_ff;
   logic          esc_ff;
   logic [7:0]    b_ff;
   logic [SW-1:0] k_ff;
   logic [CW-1:0] cnt_ff;
   logic [PW-1:0] j_ff, i_ff;
   logic [3:0]    found_ff;
   logic          rsp_valid_ff, rsp_fed_ff;
   logic [3:0]    rsp_match_ff;
   logic [7:0]    rsp_dec_ff;

   logic [CW-1:0] cur_len, cur_cnt, diff, plen_sat;
   logic [PW-1:0] off_a, off_b;
   logic [AW-1:0] base, addr_a, addr_b, wr_addr;
   logic [SW-1:0] req_idx;
   logic [7:0]    dec_byte;
   logic          slot_ok, pos_ok;
   action_type    act;

   assign act      = action_type'(req_action);
   assign cur_len  = len_ff[k_ff];
   assign cur_cnt  = cnt_tab_ff[k_ff];
   assign diff     = cnt_ff - CW'(j_ff);
   assign base     = AW'(k_ff) * AW'(PATTERN_LEN);
   assign req_idx  = req_slot[SW-1:0];
   assign slot_ok  = {1'b0, req_slot} < 5'(SLOTS);
   assign pos_ok   = 11'(req_position) < 11'(PATTERN_LEN);
   assign wr_addr  = AW'(req_idx) * AW'(PATTERN_LEN) + AW'(req_position);
   assign plen_sat = (LW'(req_pattern_length) > LW'(PATTERN_LEN)) ?
                     CW'(PATTERN_LEN) : CW'(req_pattern_length);
   // escaped byte is fed minus one
   assign dec_byte = esc_ff ? (req_byte_value - 8'd1) : req_byte_value;

   always_comb begin
      off_a = '0;
      off_b = '0;
      case (cmd.rd)
         RD_CNT:     off_a = cur_cnt[PW-1:0];
         RD_J_FIRST: off_a = PW'(cnt_ff - CW'(1));
         RD_J_DEC:   off_a = j_ff - PW'(1);
         RD_I_FIRST: off_b = diff[PW-1:0];
         RD_I_NEXT: begin
            off_a = i_ff + PW'(1);
            off_b = PW'(diff + CW'(i_ff) + CW'(1));
         end
         default: ;
      endcase
   end

   assign addr_a = base + AW'(off_a);
   assign addr_b = base + AW'(off_b);

   always_ff @(posedge clock) begin
      if (cmd.accept && act == ACT_WRITE && slot_ok && pos_ok) begin
         mem[wr_addr] <= req_byte_value;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= '0;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SLOTS; s++) begin
            len_ff[s]     <= '0;
            cnt_tab_ff[s] <= '0;
         end
      end else begin
         if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.accept) begin
            rsp_valid_ff <= 1'b1;
            rsp_match_ff <= '0;
            rsp_fed_ff   <= 1'b0;
            rsp_dec_ff   <= '0;
            unique case (act)
               ACT_RX: begin
                  if (esc_ff) begin
                     esc_ff <= 1'b0;
                  end else if (req_byte_value == ESC_BYTE) begin
                     esc_ff <= 1'b1;
                  end
                  if (sts.feed) begin
                     // word goes out after the slot scan
                     rsp_valid_ff <= 1'b0;
                     b_ff         <= dec_byte;
                     k_ff         <= '0;
                     found_ff     <= '0;
                  end
               end
               ACT_WRITE: ;
               ACT_ARM: begin
                  if (slot_ok) begin
                     len_ff[req_idx]     <= plen_sat;
                     cnt_tab_ff[req_idx] <= '0;
                     armed_ff[req_idx]   <= 1'b1;
                  end
               end
               ACT_CLEAR: begin
                  armed_ff <= '0;
                  for (int s = 0; s < SLOTS; s++) begin
                     len_ff[s]     <= '0;
                     cnt_tab_ff[s] <= '0;
                  end
               end
               default: ;
            endcase
         end

         case (cmd.cnt)
            CNT_LOAD: cnt_ff <= cur_cnt;
            CNT_INC:  cnt_ff <= cnt_ff + CW'(1);
            CNT_LEN:  cnt_ff <= cur_len;
            CNT_J1:   cnt_ff <= CW'(j_ff) + CW'(1);
            CNT_ZERO: cnt_ff <= '0;
            default:  ;
         endcase

         case (cmd.rd)
            RD_J_FIRST: j_ff <= PW'(cnt_ff - CW'(1));
            RD_J_DEC:   j_ff <= j_ff - PW'(1);
            RD_I_FIRST: i_ff <= '0;
            RD_I_NEXT:  i_ff <= i_ff + PW'(1);
            default:    ;
         endcase

         if (cmd.commit) begin
            if (armed_ff[k_ff]) begin
               cnt_tab_ff[k_ff] <= cnt_ff;
               if (cnt_ff == cur_len && found_ff == '0) begin
                  found_ff <= 4'(k_ff) + 4'd1;
               end
            end
            k_ff <= k_ff + SW'(1);
         end

         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            rsp_match_ff <= found_ff;
            rsp_fed_ff   <= 1'b1;
            rsp_dec_ff   <= b_ff;
            if (found_ff != '0) begin
               armed_ff <= '0;
               for (int s = 0; s < SLOTS; s++) begin
                  len_ff[s]     <= '0;
                  cnt_tab_ff[s] <= '0;
               end
            end
         end
      end
   end

   always_comb begin
      sts.feed      = (act == ACT_RX) && (esc_ff || req_byte_value != ESC_BYTE);
      sts.armed     = armed_ff[k_ff];
      sts.lt_len    = cnt_ff < cur_len;
      sts.cnt_zero  = cnt_ff == '0;
      sts.a_eq_b    = rd_a_ff == b_ff;
      sts.pair_eq   = rd_a_ff == rd_b_ff;
      sts.j_zero    = j_ff == '0;
      sts.i_last    = (i_ff + PW'(1)) == j_ff;
      sts.last_slot = k_ff == SW'(SLOTS - 1);
      sts.rsp_free  = !rsp_valid_ff || rsp_take;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_slot   = rsp_match_ff;
   assign rsp_byte_fed     = rsp_fed_ff;
   assign rsp_decoded_byte = rsp_dec_ff;

endmodule
`default_nettype wire

// File: rtl/mpsm_ctrl.sv
`default_nettype none
module mpsm_ctrl
   import mpsm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type sts,
   output cmd_type         cmd
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_SLOT = 7'b0000010,
      S_CMP  = 7'b0000100,
      S_FBJ  = 7'b0001000,
      S_FBI  = 7'b0010000,
      S_NEXT = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE) && sts.rsp_free;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.cnt    = CNT_KEEP;
      cmd.rd     = RD_NONE;
      cmd.commit = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               if (sts.feed) state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            if (sts.armed) begin
               cmd.cnt  = CNT_LOAD;
               cmd.rd   = RD_CNT;
               state_in = S_CMP;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_CMP: begin
            state_in = S_NEXT;
            if (sts.lt_len && sts.a_eq_b) begin
               cmd.cnt = CNT_INC;
            end else if (sts.lt_len && !sts.cnt_zero) begin
               cmd.rd   = RD_J_FIRST;
               state_in = S_FBJ;
            end else if (!sts.lt_len) begin
               cmd.cnt = CNT_LEN;
            end
         end
         // candidate border length j+1: last byte first, then the prefix
         S_FBJ: begin
            if (sts.a_eq_b) begin
               if (sts.j_zero) begin
                  cmd.cnt  = CNT_J1;
                  state_in = S_NEXT;
               end else begin
                  cmd.rd   = RD_I_FIRST;
                  state_in = S_FBI;
               end
            end else if (sts.j_zero) begin
               cmd.cnt  = CNT_ZERO;
               state_in = S_NEXT;
            end else begin
               cmd.rd = RD_J_DEC;
            end
         end
         S_FBI: begin
            if (sts.pair_eq) begin
               if (sts.i_last) begin
                  cmd.cnt  = CNT_J1;
                  state_in = S_NEXT;
               end else begin
                  cmd.rd = RD_I_NEXT;
               end
            end else begin
               cmd.rd   = RD_J_DEC;
               state_in = S_FBJ;
            end
         end
         S_NEXT: begin
            cmd.commit = 1'b1;
            state_in   = sts.last_slot ? S_FIN : S_SLOT;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: dv/multi_pattern_stream_matcher_checker.sv
`default_nettype none
module multi_pattern_stream_matcher_checker
   import mpsm_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   mpsm_req_if      req_bus,
   mpsm_rsp_if      rsp_bus,
   output int       failures,
   output int       pending
);

   localparam int NSLOT = DEF_SLOTS;
   localparam int PLEN  = DEF_PATTERN_LEN;

   typedef struct {
      logic [3:0] match_slot;
      logic       byte_fed;
      logic [7:0] decoded_byte;
   } match_word_type;

   logic [7:0] pat_bytes [NSLOT][PLEN];
   int         pat_len   [NSLOT];
   bit         armed     [NSLOT];
   int         progress  [NSLOT];
   bit         esc_seen;
   match_word_type expected_words [$];
   int         fail_count = 0;
   int         queued = 0;

   assign failures = fail_count;
   assign pending  = queued;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic void drop_all();
      for (int s = 0; s < NSLOT; s++) begin
         armed[s] = 0;
         pat_len[s] = 0;
         progress[s] = 0;
      end
   endfunction

   // longest prefix ending in b that is a suffix of the matched text plus b
   function automatic int border_step(input int s, input int cnt, input logic [7:0] b);
      bit same;
      for (int j = cnt - 1; j >= 0; j--) begin
         if (pat_bytes[s][j] == b) begin
            same = 1;
            for (int i = 0; i < j; i++)
               if (pat_bytes[s][i] != pat_bytes[s][cnt - j + i]) same = 0;
            if (same) return j + 1;
         end
      end
      return 0;
   endfunction

   function automatic logic [3:0] advance_slots(input logic [7:0] b);
      logic [3:0] hit;
      int c;
      hit = 0;
      for (int s = NSLOT - 1; s >= 0; s--) begin
         if (armed[s]) begin
            c = progress[s];
            if (c < pat_len[s] && pat_bytes[s][c] == b) c++;
            else if (c > 0 && c < pat_len[s]) c = border_step(s, c, b);
            else if (c >= pat_len[s]) c = pat_len[s];
            progress[s] = c;
            if (c == pat_len[s]) hit = 4'(s + 1);
         end
      end
      if (hit != 0) drop_all();
      return hit;
   endfunction

   function automatic match_word_type predict_word(input action_type act,
                                                   input logic [3:0] slot,
                                                   input logic [7:0] pos,
                                                   input logic [7:0] val,
                                                   input logic [8:0] len);
      match_word_type w;
      w = '{default: 0};
      case (act)
         ACT_RX: begin
            if (esc_seen) begin
               esc_seen = 0;
               w.byte_fed = 1;
               w.decoded_byte = val - 8'd1;
            end else if (val == ESC_BYTE) begin
               esc_seen = 1;
            end else begin
               w.byte_fed = 1;
               w.decoded_byte = val;
            end
            if (w.byte_fed) w.match_slot = advance_slots(w.decoded_byte);
         end
         ACT_WRITE: begin
            if (slot < NSLOT) pat_bytes[slot][pos] = val;
         end
         ACT_ARM: begin
            if (slot < NSLOT) begin
               pat_len[slot] = (len > PLEN) ? PLEN : int'(len);
               progress[slot] = 0;
               armed[slot] = 1;
            end
         end
         default: drop_all();
      endcase
      return w;
   endfunction

   always @(posedge clock) begin
      match_word_type w;
      if (reset) begin
         esc_seen = 0;
         drop_all();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
               report("unexpected word", rsp_bus.match_slot, 0);
            end else begin
               w = expected_words.pop_front();
               if (rsp_bus.match_slot !== w.match_slot)
                  report("match_slot", rsp_bus.match_slot, w.match_slot);
               if (rsp_bus.byte_fed !== w.byte_fed)
                  report("byte_fed", rsp_bus.byte_fed, w.byte_fed);
               if (rsp_bus.decoded_byte !== w.decoded_byte)
                  report("decoded_byte", rsp_bus.decoded_byte, w.decoded_byte);
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_words.push_back(predict_word(action_type'(req_bus.action), req_bus.slot,
                                                  req_bus.position, req_bus.byte_value,
                                                  req_bus.pattern_length));
         queued = expected_words.size();
      end
   end

endmodule
`default_nettype wire

// File: dv/multi_pattern_stream_matcher_tb.sv
`default_nettype none
module multi_pattern_stream_matcher_tb;
   import mpsm_pkg::*;

   localparam int NSLOT     = DEF_SLOTS;
   localparam int STALL_MAX = 400000;

   logic clock = 0;
   logic reset = 1;
   int   failures;
   int   pending;
   int   words_sent = 0;
   int   tx_idle_pct = 16;
   int   rx_idle_pct = 48;
   int   quiet_cycles = 0;

   // host-side copy of what was written, so feeding never walks unwritten bytes
   logic [7:0] host_pat [NSLOT][256];
   int         written  [NSLOT];

   mpsm_req_if req_bus ();
   mpsm_rsp_if rsp_bus ();

   multi_pattern_stream_matcher dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   multi_pattern_stream_matcher_checker checker_i (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .failures(failures),
      .pending (pending)
   );

   always #5 clock = ~clock;

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send(input action_type act, input int slot, input int pos,
                       input int val, input int len);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.action = act;
      req_bus.slot = 4'(slot);
      req_bus.position = 8'(pos);
      req_bus.byte_value = 8'(val);
      req_bus.pattern_length = 9'(len);
      req_bus.valid = 1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic write_byte(input int slot, input int pos, input int val);
      send(ACT_WRITE, slot, pos, val, $urandom_range(511));
      if (slot < NSLOT) begin
         host_pat[slot][pos] = 8'(val);
         if (pos == written[slot]) written[slot] = pos + 1;
      end
   endtask

   // feed one decoded byte, escaping it when needed or at random
   task automatic feed(input logic [7:0] b);
      if (b == ESC_BYTE || $urandom_range(5) == 0) begin
         send(ACT_RX, $urandom_range(15), $urandom_range(255), ESC_BYTE, $urandom_range(511));
         send(ACT_RX, $urandom_range(15), $urandom_range(255), b + 8'd1, $urandom_range(511));
      end else begin
         send(ACT_RX, $urandom_range(15), $urandom_range(255), b, $urandom_range(511));
      end
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(5))
         0: return 8'h61;
         1: return 8'h62;
         2: return 8'h00;
         3: return ESC_BYTE;
         4: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   initial begin
      int s, n, r;
      bit drained;
      drained = 0;
      req_bus.valid = 0;
      req_bus.action = ACT_RX;
      req_bus.slot = 0;
      req_bus.position = 0;
      req_bus.byte_value = 0;
      req_bus.pattern_length = 0;
      foreach (written[i]) written[i] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed
      write_byte(0, 0, 8'h61);
      write_byte(0, 1, 8'h62);
      write_byte(9, 255, 8'hFF);
      write_byte(15, 0, 8'h55);
      send(ACT_ARM, 12, 0, 0, 511);
      send(ACT_ARM, 0, 0, 0, 2);
      send(ACT_ARM, 1, 0, 0, 0);
      send(ACT_RX, 0, 0, 8'h61, 0);
      send(ACT_ARM, 0, 0, 0, 2);
      send(ACT_RX, 0, 0, 8'h61, 0);
      send(ACT_RX, 0, 0, ESC_BYTE, 0);
      send(ACT_RX, 0, 0, 8'h63, 0);
      send(ACT_RX, 0, 0, ESC_BYTE, 0);
      send(ACT_RX, 0, 0, 8'h00, 0);
      send(ACT_RX, 0, 0, 8'hFF, 0);
      send(ACT_ARM, 0, 0, 0, 2);
      send(ACT_RX, 0, 0, 8'h61, 0);
      write_byte(0, 1, 8'h61);
      send(ACT_RX, 0, 0, 8'h61, 0);
      send(ACT_ARM, 3, 0, 0, 300);
      send(ACT_CLEAR, 15, 255, 255, 511);

      while (words_sent < 900) begin
         if (words_sent < 300) begin
            tx_idle_pct = 16; rx_idle_pct = 48;
         end else if (words_sent < 600) begin
            tx_idle_pct = 48; rx_idle_pct = 16;
         end else begin
            tx_idle_pct = 0; rx_idle_pct = 0;
         end
         if (words_sent >= 450 && !drained) begin
            drained = 1;
            req_bus.valid = 0;
            while (pending != 0) @(negedge clock);
         end
         r = $urandom_range(99);
         s = $urandom_range(NSLOT - 1);
         if (r < 12) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++) write_byte(s, i, pick_byte());
         end else if (r < 30) begin
            send(ACT_ARM, s, $urandom_range(255), $urandom_range(255),
                 $urandom_range(written[s]));
         end else if (r < 34) begin
            send(ACT_CLEAR, $urandom_range(15), $urandom_range(255), $urandom_range(255),
                 $urandom_range(511));
         end else if (r < 37) begin
            // ignored slots carry any length and position
            send($urandom_range(1) ? ACT_ARM : ACT_WRITE, $urandom_range(NSLOT, 15),
                 $urandom_range(255), $urandom_range(255), $urandom_range(511));
         end else if (r < 70 && written[s] > 0) begin
            n = $urandom_range(1, written[s]);
            for (int i = 0; i < n; i++) feed(host_pat[s][i]);
         end else begin
            repeat ($urandom_range(1, 6)) feed(pick_byte());
         end
      end
      req_bus.valid = 0;

      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: multi_pattern_stream_matcher.f
rtl/mpsm_pkg.sv
rtl/mpsm_req_if.sv
rtl/mpsm_rsp_if.sv
rtl/mpsm_dp.sv
rtl/mpsm_ctrl.sv
rtl/multi_pattern_stream_matcher.sv
dv/multi_pattern_stream_matcher_checker.sv
dv/multi_pattern_stream_matcher_tb.sv
